// ===== design/cdm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdm_pkg
// Shared types, codes and default sizes of the coherent data-cache model.
// ----------------------------------------------------------------------------
package cdm_pkg;

    localparam int DEF_NUM_CPUS  = 4;
    localparam int DEF_LINES     = 256;
    localparam int DEF_WAY_BITS  = 2;
    localparam int DEF_LINE_BITS = 5;
    localparam int MAX_WAY_BITS  = 3;

    localparam logic [31:0] TAG_RESET_WORD = 32'h8BAD_F00D;
    localparam logic [15:0] LFSR_SEED      = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS      = 16'hB400;

    localparam logic [2:0]  ACTIVE_RESET  = 3'd4;
    localparam logic [15:0] LATENCY_RESET = 16'd100;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_CPUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_MISS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_LAT   = 2'd2;

    typedef enum logic [1:0] {
        FN_LOAD  = 2'd0,
        FN_STORE = 2'd1,
        FN_INVAL = 2'd2,
        FN_NONE  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        LS_INV = 2'd0,
        LS_SHR = 2'd1,
        LS_MOD = 2'd2
    } line_st_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_P_RD,
        ST_P_LK,
        ST_S_RD,
        ST_S_WR,
        ST_DONE
    } ctl_state_t;

    typedef struct packed {
        logic                    hit;
        logic [MAX_WAY_BITS-1:0] hit_way;
        logic [1:0]              hit_state;
        logic                    has_inv;
        logic [MAX_WAY_BITS-1:0] inv_way;
    } match_t;

    typedef struct packed {
        logic [2:0]      count;
        logic [7:0][2:0] offs;
    } split_t;

endpackage
`default_nettype wire

// ===== design/cdm_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdm_if
// Request and result channels of the coherent data-cache model.
// ----------------------------------------------------------------------------
interface cdm_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [1:0]  requester;
    logic [31:0] address;
    logic [1:0]  size_code;

    modport source (output valid, func, requester, address, size_code, input ready);
    modport sink   (input valid, func, requester, address, size_code, output ready);
endinterface

interface cdm_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  pieces;
    logic [2:0]  read_misses;
    logic [2:0]  memory_reads;
    logic [2:0]  memory_writes;
    logic [18:0] latency_added;

    modport source (output valid, pieces, read_misses, memory_reads, memory_writes,
                    latency_added, input ready);
    modport sink   (input valid, pieces, read_misses, memory_reads, memory_writes,
                    latency_added, output ready);
endinterface
`default_nettype wire

// ===== design/cdm_tag_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdm_tag_ram
// One-write one-read tag and state memory, one set of one cache per row.
// ----------------------------------------------------------------------------
module cdm_tag_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 116,
    parameter int AW    = 8
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== design/cdm_way_match.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdm_way_match
// Shared set compare: first way with a matching tag and first Invalid way.
// ----------------------------------------------------------------------------
module cdm_way_match #(
    parameter int WAY_BITS = 2,
    parameter int TW       = 27
) (
    input  wire logic [(1<<WAY_BITS)-1:0][TW-1:0] tags,
    input  wire logic [(1<<WAY_BITS)-1:0][1:0]    states,
    input  wire logic [TW-1:0]                    tag,
    output cdm_pkg::match_t                       result
);
    import cdm_pkg::*;

    localparam int WAYS = 1 << WAY_BITS;

    always_comb
    begin
        result = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (tags[w] == tag)
            begin
                result.hit       = 1'b1;
                result.hit_way   = MAX_WAY_BITS'(w);
                result.hit_state = states[w];
            end
            if (states[w] == LS_INV)
            begin
                result.has_inv = 1'b1;
                result.inv_way = MAX_WAY_BITS'(w);
            end
        end
    end

endmodule
`default_nettype wire

// ===== design/cdm_piece_split.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdm_piece_split
// Break an access into line-contained pieces, as byte offsets from its base.
// ----------------------------------------------------------------------------
module cdm_piece_split #(
    parameter int LINE_BITS = 5
) (
    input  wire logic [31:0] address,
    input  wire logic [1:0]  size_code,
    output cdm_pkg::split_t  split
);
    import cdm_pkg::*;

    localparam int LS = 1 << LINE_BITS;

    typedef struct packed {
        logic [2:0]      n;
        logic [3:0][2:0] o;
    } word_t;

    function automatic logic fits(input logic [31:0] a, input logic [2:0] n);
        logic [LINE_BITS:0] s;
        s = {1'b0, a[LINE_BITS-1:0]} + (LINE_BITS+1)'(n);
        return s < (LINE_BITS+1)'(LS);
    endfunction

    function automatic word_t word(input logic [31:0] a, input logic [2:0] o);
        word_t       r;
        logic [31:0] x;
        logic [2:0]  k;
        r = '0;
        x = a + 32'(o);
        k = '0;
        if (fits(x, 3'd3))
        begin
            r.o[0] = o;
            k      = 3'd1;
        end
        else if (x[0])
        begin
            r.o[0] = o;
            r.o[1] = o + 3'd1;
            k      = 3'd2;
            if (!fits(x + 32'd1, 3'd1))
            begin
                r.o[2] = o + 3'd2;
                k      = 3'd3;
            end
            r.o[k[1:0]] = o + 3'd3;
            k           = k + 3'd1;
        end
        else
        begin
            r.o[0] = o;
            k      = 3'd1;
            if (!fits(x, 3'd1))
            begin
                r.o[1] = o + 3'd1;
                k      = 3'd2;
            end
            r.o[k[1:0]] = o + 3'd2;
            k           = k + 3'd1;
            if (!fits(x + 32'd2, 3'd1))
            begin
                r.o[k[1:0]] = o + 3'd3;
                k           = k + 3'd1;
            end
        end
        r.n = k;
        return r;
    endfunction

    word_t w0;
    word_t w1;

    always_comb
    begin
        w0    = word(address, 3'd0);
        w1    = word(address, 3'd4);
        split = '0;
        case (size_code)
            2'd0:
            begin
                split.count = 3'd1;
            end
            2'd1:
            begin
                split.offs[1] = 3'd1;
                split.count   = fits(address, 3'd1) ? 3'd1 : 3'd2;
            end
            2'd2:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    split.offs[i] = w0.o[i];
                end
                split.count = w0.n;
            end
            default:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    if (3'(i) < w0.n)
                    begin
                        split.offs[i] = w0.o[i];
                    end
                end
                for (int i = 0; i < 4; i++)
                begin
                    if (3'(i) < w1.n)
                    begin
                        split.offs[3'(i) + w0.n] = w1.o[i];
                    end
                end
                split.count = w0.n + w1.n;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== design/coherent_dcache_model.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// coherent_dcache_model
// Per-CPU set-associative write-through caches kept coherent by MSI snooping.
// ----------------------------------------------------------------------------
// Usage:
//   req: func, requester, address, size_code; one transfer per access.
//   rsp: one result transfer per access (piece count, misses, traffic,
//        added latency).
//   cfg_we/cfg_index/cfg_data: write active_cpus, read_miss_latency and
//        write_latency while the block is idle.
// After reset a clearing pass writes every row of the tag memory, one set of
// one cache per cycle, NUM_CPUS * LINES_PER_CACHE / WAYS rows (256 with the
// defaults); req.ready stays low meanwhile.
// Each access is accepted in idle; each piece then has a tag read and a
// lookup. A piece that snoops then reads and updates each other active cache
// in turn, passing over the requester slot, and finishes; last, the result is
// handed over. All lookups share one tag memory port and one set compare unit.
// The result sits in an output register; req.ready returns while it waits,
// and a finished next result holds until rsp takes the previous one.
// ----------------------------------------------------------------------------
module coherent_dcache_model #(
    parameter int NUM_CPUS        = cdm_pkg::DEF_NUM_CPUS,
    parameter int LINES_PER_CACHE = cdm_pkg::DEF_LINES,
    parameter int WAY_BITS        = cdm_pkg::DEF_WAY_BITS,
    parameter int LINE_BITS       = cdm_pkg::DEF_LINE_BITS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    cdm_req_if.sink                             req,
    cdm_rsp_if.source                           rsp,
    input  wire logic                           cfg_we,
    input  wire logic [cdm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cdm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import cdm_pkg::*;

    localparam int WAYS  = 1 << WAY_BITS;
    localparam int TW    = 32 - LINE_BITS;
    localparam int SETS  = LINES_PER_CACHE / WAYS;
    localparam int ROWS  = NUM_CPUS * SETS;
    localparam int RAW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CPU_W = $clog2(NUM_CPUS + 1);
    localparam int WIW   = (WAY_BITS > 0) ? WAY_BITS : 1;
    localparam int ROW_W = WAYS * (TW + 2);
    localparam logic [TW-1:0] TAG_RST = TAG_RESET_WORD[TW-1:0];

    function automatic logic [RAW-1:0] row_of(input logic [CPU_W-1:0] c,
                                              input logic [TW-1:0] t);
        logic [31:0] set_num;
        set_num = (32'(t) & 32'(LINES_PER_CACHE - 1)) >> WAY_BITS;
        return RAW'(32'(c) * 32'(SETS) + set_num);
    endfunction

    ctl_state_t state_reg, state_next;
    logic [RAW-1:0]  clr_reg, clr_next;
    logic [15:0]     lfsr_reg, lfsr_next;
    logic [2:0]      active_reg;
    logic [15:0]     rml_reg;
    logic [15:0]     wl_reg;
    logic            out_valid_reg, out_valid_next;

    func_t           func_reg, func_next;
    logic [CPU_W-1:0] cpu_reg, cpu_next;
    logic [31:0]     addr_reg, addr_next;
    logic [7:0][2:0] offs_reg, offs_next;
    logic [2:0]      cnt_reg, cnt_next;
    logic [2:0]      idx_reg, idx_next;
    logic [CPU_W-1:0] snp_reg, snp_next;
    logic [TW-1:0]   tag_reg, tag_next;
    logic [RAW-1:0]  row_reg, row_next;
    logic [2:0]      rmiss_reg, rmiss_next;
    logic [2:0]      mread_reg, mread_next;
    logic [2:0]      mwrite_reg, mwrite_next;
    logic [18:0]     lat_reg, lat_next;
    logic [2:0]      o_pieces_reg, o_rmiss_reg, o_mread_reg, o_mwrite_reg;
    logic [18:0]     o_lat_reg;
    logic            o_load;

    logic            ram_we;
    logic [RAW-1:0]  ram_waddr;
    logic [RAW-1:0]  ram_raddr;
    logic [ROW_W-1:0] ram_wdata;
    logic [ROW_W-1:0] ram_rdata;

    logic [WAYS-1:0][TW-1:0] r_tags;
    logic [WAYS-1:0][1:0]    r_states;
    logic [WAYS-1:0][TW-1:0] w_tags;
    logic [WAYS-1:0][1:0]    w_states;
    logic [WAYS-1:0][TW-1:0] clr_tags;

    match_t          m;
    split_t          split;
    logic [31:0]     piece_addr;
    logic [CPU_W-1:0] cpu_in;
    logic [CPU_W-1:0] lim;
    logic [15:0]     lfsr_step;
    logic            miss;
    logic [MAX_WAY_BITS-1:0] vict;
    logic [MAX_WAY_BITS-1:0] way;
    logic [1:0]      cur_st;
    logic            accept;

    cdm_tag_ram #(
        .DEPTH (ROWS),
        .WIDTH (ROW_W),
        .AW    (RAW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    cdm_way_match #(
        .WAY_BITS (WAY_BITS),
        .TW       (TW)
    ) u_match (
        .tags   (r_tags),
        .states (r_states),
        .tag    (tag_reg),
        .result (m)
    );

    cdm_piece_split #(
        .LINE_BITS (LINE_BITS)
    ) u_split (
        .address   (req.address),
        .size_code (req.size_code),
        .split     (split)
    );

    assign r_tags   = ram_rdata[WAYS*TW-1:0];
    assign r_states = ram_rdata[ROW_W-1:WAYS*TW];

    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            clr_tags[w] = TAG_RST;
        end
    end

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign piece_addr = addr_reg + 32'(offs_reg[idx_reg]);
    assign lfsr_step = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ LFSR_TAPS) : (lfsr_reg >> 1);
    assign lim = (32'(active_reg) < NUM_CPUS) ? CPU_W'(active_reg) : CPU_W'(NUM_CPUS);

    always_comb
    begin
        if (NUM_CPUS == 1)
        begin
            cpu_in = '0;
        end
        else if (32'(req.requester) >= NUM_CPUS)
        begin
            cpu_in = CPU_W'(32'(req.requester) - 32'(NUM_CPUS));
        end
        else
        begin
            cpu_in = CPU_W'(req.requester);
        end
    end

    always_comb
    begin
        miss   = !m.hit || (m.hit_state == LS_INV);
        vict   = m.has_inv ? m.inv_way
               : ((WAY_BITS == 0) ? '0 : MAX_WAY_BITS'(lfsr_step[WIW-1:0]));
        way    = miss ? vict : m.hit_way;
        cur_st = miss ? 2'(LS_INV) : m.hit_state;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            lfsr_reg      <= LFSR_SEED;
            active_reg    <= ACTIVE_RESET;
            rml_reg       <= LATENCY_RESET;
            wl_reg        <= LATENCY_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            lfsr_reg      <= lfsr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_ACTIVE_CPUS: active_reg <= cfg_data[2:0];
                    CFG_READ_MISS:   rml_reg    <= cfg_data;
                    CFG_WRITE_LAT:   wl_reg     <= cfg_data;
                    default:         ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        cpu_reg    <= cpu_next;
        addr_reg   <= addr_next;
        offs_reg   <= offs_next;
        cnt_reg    <= cnt_next;
        idx_reg    <= idx_next;
        snp_reg    <= snp_next;
        tag_reg    <= tag_next;
        row_reg    <= row_next;
        rmiss_reg  <= rmiss_next;
        mread_reg  <= mread_next;
        mwrite_reg <= mwrite_next;
        lat_reg    <= lat_next;
        if (o_load)
        begin
            o_pieces_reg <= cnt_reg;
            o_rmiss_reg  <= rmiss_reg;
            o_mread_reg  <= mread_reg;
            o_mwrite_reg <= mwrite_reg;
            o_lat_reg    <= lat_reg;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        lfsr_next   = lfsr_reg;
        func_next   = func_reg;
        cpu_next    = cpu_reg;
        addr_next   = addr_reg;
        offs_next   = offs_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        snp_next    = snp_reg;
        tag_next    = tag_reg;
        row_next    = row_reg;
        rmiss_next  = rmiss_reg;
        mread_next  = mread_reg;
        mwrite_next = mwrite_reg;
        lat_next    = lat_reg;
        o_load      = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = row_reg;
        ram_raddr   = row_reg;
        w_tags      = r_tags;
        w_states    = r_states;
        ram_wdata   = {w_states, w_tags};
        out_valid_next = out_valid_reg && !rsp.ready;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = {{(2*WAYS){1'b0}}, clr_tags};
                clr_next  = clr_reg + RAW'(1);
                if (32'(clr_reg) == ROWS - 1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    func_next   = func_t'(req.func);
                    cpu_next    = cpu_in;
                    addr_next   = req.address;
                    idx_next    = '0;
                    rmiss_next  = '0;
                    mread_next  = '0;
                    mwrite_next = '0;
                    lat_next    = '0;
                    offs_next   = split.offs;
                    cnt_next    = split.count;
                    state_next  = ST_P_RD;
                    if (func_t'(req.func) == FN_NONE)
                    begin
                        cnt_next   = '0;
                        state_next = ST_DONE;
                    end
                    else if (func_t'(req.func) == FN_INVAL)
                    begin
                        offs_next = '0;
                        cnt_next  = 3'd1;
                    end
                end
            end
            ST_P_RD:
            begin
                tag_next  = piece_addr[31:LINE_BITS];
                row_next  = row_of(cpu_reg, piece_addr[31:LINE_BITS]);
                ram_raddr = row_next;
                state_next = ST_P_LK;
            end
            ST_P_LK:
            begin
                snp_next = '0;
                if (func_reg == FN_INVAL)
                begin
                    if (m.hit)
                    begin
                        w_states[m.hit_way[WIW-1:0]] = LS_INV;
                        ram_we = 1'b1;
                    end
                    state_next = ST_DONE;
                end
                else
                begin
                    if (miss && !m.has_inv)
                    begin
                        lfsr_next = lfsr_step;
                    end
                    w_tags[way[WIW-1:0]] = tag_reg;
                    if (func_reg == FN_STORE)
                    begin
                        w_states[way[WIW-1:0]] = LS_MOD;
                        ram_we      = 1'b1;
                        mwrite_next = mwrite_reg + 3'd1;
                        lat_next    = lat_reg + 19'(wl_reg);
                        state_next  = (cur_st != LS_MOD) ? ST_S_RD : ST_P_RD;
                    end
                    else if (miss)
                    begin
                        w_states[way[WIW-1:0]] = LS_SHR;
                        ram_we      = 1'b1;
                        rmiss_next  = rmiss_reg + 3'd1;
                        mread_next  = mread_reg + 3'd1;
                        lat_next    = lat_reg + 19'(rml_reg);
                        state_next  = ST_S_RD;
                    end
                    else
                    begin
                        state_next = ST_P_RD;
                    end
                    if (state_next == ST_P_RD)
                    begin
                        idx_next = idx_reg + 3'd1;
                        if (idx_reg + 3'd1 == cnt_reg)
                        begin
                            state_next = ST_DONE;
                        end
                    end
                end
                ram_wdata = {w_states, w_tags};
            end
            ST_S_RD:
            begin
                if (snp_reg >= lim)
                begin
                    idx_next   = idx_reg + 3'd1;
                    state_next = (idx_reg + 3'd1 == cnt_reg) ? ST_DONE : ST_P_RD;
                end
                else if (snp_reg == cpu_reg)
                begin
                    snp_next = snp_reg + CPU_W'(1);
                end
                else
                begin
                    row_next   = row_of(snp_reg, tag_reg);
                    ram_raddr  = row_next;
                    state_next = ST_S_WR;
                end
            end
            ST_S_WR:
            begin
                if (m.hit)
                begin
                    if (func_reg == FN_STORE)
                    begin
                        w_states[m.hit_way[WIW-1:0]] = LS_INV;
                        ram_we = 1'b1;
                    end
                    else if (m.hit_state == LS_MOD)
                    begin
                        w_states[m.hit_way[WIW-1:0]] = LS_SHR;
                        ram_we = 1'b1;
                    end
                end
                ram_wdata  = {w_states, w_tags};
                snp_next   = snp_reg + CPU_W'(1);
                state_next = ST_S_RD;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    o_load         = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.pieces        = o_pieces_reg;
    assign rsp.read_misses   = o_rmiss_reg;
    assign rsp.memory_reads  = o_mread_reg;
    assign rsp.memory_writes = o_mwrite_reg;
    assign rsp.latency_added = o_lat_reg;

    a_fill_per_miss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> o_rmiss_reg == o_mread_reg)
        else $error("fill count differs from read miss count");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !ram_we)
        else $error("tag memory written while idle");

    a_snoop_other: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_S_WR |-> snp_reg != cpu_reg && $past(state_reg) == ST_S_RD)
        else $error("snoop reached the requester cache");

    a_piece_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_P_LK |-> idx_reg < cnt_reg)
        else $error("piece index past piece count");

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the coherent data-cache model. A local MSI cache
// predictor tracks tags, line states and the victim LFSR. It computes the
// piece count, misses, memory traffic and latency of every accepted access.
// These are checked in order against the result channel. The run has
// directed corner accesses, then phases of clustered random traffic under
// varied idle patterns and register settings.
// ----------------------------------------------------------------------------
module tb_top;
    import cdm_pkg::*;

    localparam int NCPU      = 4;
    localparam int NLINES    = 256;
    localparam int NWAYS     = 4;
    localparam int MAX_CYCLE = 3000000;

    typedef struct {
        func_t       fn;
        logic [1:0]  cpu;
        logic [31:0] addr;
        logic [1:0]  sz;
    } access_t;

    typedef struct {
        logic [2:0]  pieces;
        logic [2:0]  rmiss;
        logic [2:0]  mrd;
        logic [2:0]  mwr;
        logic [18:0] lat;
    } outcome_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    cdm_req_if req_ch ();
    cdm_rsp_if rsp_ch ();

    coherent_dcache_model dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    logic [26:0] tag_mem [NCPU*NLINES];
    line_st_t    lstate  [NCPU*NLINES];
    logic [15:0] lfsr;
    logic [2:0]  act_cpus;
    logic [15:0] rd_lat;
    logic [15:0] wr_lat;
    int          n_pc, n_rm, n_mr, n_mw, n_lat;

    access_t  pending_q [$];
    outcome_t outcome_q [$];

    int  send_idle;
    int  rsp_stall;
    bit  took;
    int  errors;
    int  checked;
    int  cycles;
    int  n_loads, n_stores, n_inval;
    logic [18:0] hi_pool [8];

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int slot(int cpu, int line);
        return cpu * NLINES + (line % NLINES);
    endfunction

    function automatic int find_way(int cpu, int base, logic [26:0] tg);
        for (int w = 0; w < NWAYS; w++)
            if (tag_mem[slot(cpu, base + w)] == tg)
                return w;
        return -1;
    endfunction

    task automatic choose_victim(input int cpu, input int base, output int way);
        for (int w = 0; w < NWAYS; w++)
        begin
            if (lstate[slot(cpu, base + w)] == LS_INV)
            begin
                way = w;
                return;
            end
        end
        lfsr = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);
        way = lfsr[1:0];
    endtask

    task automatic do_piece(input bit is_st, input int cpu, input logic [31:0] a);
        logic [26:0] tg;
        int base, lim, w, s, ic;
        bit miss;
        tg = a[31:5];
        base = tg[7:0] & 8'hFC;
        lim = (act_cpus < NCPU) ? act_cpus : NCPU;
        w = find_way(cpu, base, tg);
        miss = (w < 0) || (lstate[slot(cpu, base + w)] == LS_INV);
        n_pc++;
        if (miss)
        begin
            choose_victim(cpu, base, w);
            s = slot(cpu, base + w);
            tag_mem[s] = tg;
            lstate[s] = LS_INV;
        end
        s = slot(cpu, base + w);
        if (!is_st)
        begin
            if (!miss)
                return;
            lstate[s] = LS_SHR;
            for (int c = 0; c < lim; c++)
            begin
                if (c == cpu)
                    continue;
                ic = find_way(c, base, tg);
                if (ic >= 0 && lstate[slot(c, base + ic)] == LS_MOD)
                    lstate[slot(c, base + ic)] = LS_SHR;
            end
            n_rm++;
            n_mr++;
            n_lat += rd_lat;
            return;
        end
        if (lstate[s] != LS_MOD)
        begin
            lstate[s] = LS_MOD;
            for (int c = 0; c < lim; c++)
            begin
                if (c == cpu)
                    continue;
                ic = find_way(c, base, tg);
                if (ic >= 0)
                    lstate[slot(c, base + ic)] = LS_INV;
            end
        end
        n_mw++;
        n_lat += wr_lat;
    endtask

    task automatic do_half(input bit is_st, input int cpu, input logic [31:0] a);
        do_piece(is_st, cpu, a);
        if (a[4:0] == 5'd31)
            do_piece(is_st, cpu, a + 32'd1);
    endtask

    task automatic do_word(input bit is_st, input int cpu, input logic [31:0] a);
        if (a[4:0] + 6'd3 < 6'd32)
            do_piece(is_st, cpu, a);
        else if (a[0])
        begin
            do_piece(is_st, cpu, a);
            do_half(is_st, cpu, a + 32'd1);
            do_piece(is_st, cpu, a + 32'd3);
        end
        else
        begin
            do_half(is_st, cpu, a);
            do_half(is_st, cpu, a + 32'd2);
        end
    endtask

    task automatic predict_access(input access_t t);
        outcome_t o;
        logic [26:0] tg;
        int base, w;
        bit is_st;
        n_pc = 0; n_rm = 0; n_mr = 0; n_mw = 0; n_lat = 0;
        is_st = (t.fn == FN_STORE);
        case (t.fn)
            FN_LOAD, FN_STORE:
            begin
                case (t.sz)
                    2'd0: do_piece(is_st, t.cpu, t.addr);
                    2'd1: do_half(is_st, t.cpu, t.addr);
                    2'd2: do_word(is_st, t.cpu, t.addr);
                    default:
                    begin
                        do_word(is_st, t.cpu, t.addr);
                        do_word(is_st, t.cpu, t.addr + 32'd4);
                    end
                endcase
            end
            FN_INVAL:
            begin
                tg = t.addr[31:5];
                base = tg[7:0] & 8'hFC;
                w = find_way(t.cpu, base, tg);
                if (w >= 0)
                    lstate[slot(t.cpu, base + w)] = LS_INV;
                n_pc = 1;
            end
            default: ;
        endcase
        o.pieces = n_pc[2:0];
        o.rmiss  = n_rm[2:0];
        o.mrd    = n_mr[2:0];
        o.mwr    = n_mw[2:0];
        o.lat    = n_lat[18:0];
        outcome_q.push_back(o);
    endtask

    // monitor: check results, then predict newly accepted accesses
    always @(posedge clk)
    begin
        outcome_t e;
        access_t  t;
        took = req_ch.valid && req_ch.ready && rst_n;
        cycles++;
        if (cycles > MAX_CYCLE)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end
        else
        begin
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                if (outcome_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result transfer at cycle %0d", cycles);
                end
                else
                begin
                    e = outcome_q.pop_front();
                    checked++;
                    if (rsp_ch.pieces !== e.pieces || rsp_ch.read_misses !== e.rmiss ||
                        rsp_ch.memory_reads !== e.mrd || rsp_ch.memory_writes !== e.mwr ||
                        rsp_ch.latency_added !== e.lat)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("mismatch #%0d: exp pc=%0d rm=%0d mr=%0d mw=%0d lat=%0d",
                                     checked, e.pieces, e.rmiss, e.mrd, e.mwr, e.lat);
                            $display("    got pc=%0d rm=%0d mr=%0d mw=%0d lat=%0d",
                                     rsp_ch.pieces, rsp_ch.read_misses,
                                     rsp_ch.memory_reads, rsp_ch.memory_writes,
                                     rsp_ch.latency_added);
                        end
                    end
                end
            end
            if (took)
            begin
                t.fn   = func_t'(req_ch.func);
                t.cpu  = req_ch.requester;
                t.addr = req_ch.address;
                t.sz   = req_ch.size_code;
                predict_access(t);
            end
        end
    end

    // driver: advance the request channel after each transfer
    always @(negedge clk)
    begin
        access_t t;
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else if (!req_ch.valid || took)
        begin
            if (pending_q.size() > 0 && $urandom_range(99) >= send_idle)
            begin
                t = pending_q.pop_front();
                req_ch.valid     <= 1'b1;
                req_ch.func      <= t.fn;
                req_ch.requester <= t.cpu;
                req_ch.address   <= t.addr;
                req_ch.size_code <= t.sz;
            end
            else
                req_ch.valid <= 1'b0;
        end
        rsp_ch.ready <= ($urandom_range(99) >= rsp_stall);
    end

    task automatic add_access(input func_t fn, input logic [1:0] cpu,
                              input logic [31:0] a, input logic [1:0] sz);
        access_t t;
        t.fn = fn; t.cpu = cpu; t.addr = a; t.sz = sz;
        pending_q.push_back(t);
        case (fn)
            FN_LOAD:  n_loads++;
            FN_STORE: n_stores++;
            FN_INVAL: n_inval++;
            default: ;
        endcase
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_ACTIVE_CPUS: act_cpus = val[2:0];
            CFG_READ_MISS:   rd_lat = val;
            CFG_WRITE_LAT:   wr_lat = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending_q.size() > 0 || outcome_q.size() > 0 || req_ch.valid)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_addr();
        int r;
        logic [6:0] lo;
        r = $urandom_range(99);
        if (r < 8)
            return $urandom;
        if (r < 11)
            return 32'hFFFF_FFE0 | $urandom_range(31);
        lo = 7'($urandom_range(127));
        if ($urandom_range(1))
            lo[4:0] = 5'(24 + $urandom_range(7));
        return {hi_pool[$urandom_range(7)], 6'($urandom_range(3)), lo};
    endfunction

    task automatic random_phase(input int count);
        int r;
        func_t fn;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            fn = (r < 45) ? FN_LOAD : (r < 85) ? FN_STORE : (r < 97) ? FN_INVAL : FN_NONE;
            add_access(fn, 2'($urandom_range(3)), rand_addr(), 2'($urandom_range(3)));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.func = '0;
        req_ch.requester = '0;
        req_ch.address = '0;
        req_ch.size_code = '0;
        rsp_ch.ready = 1'b0;
        send_idle = 0;
        rsp_stall = 0;
        took = 1'b0;
        errors = 0;
        checked = 0;
        cycles = 0;
        n_loads = 0; n_stores = 0; n_inval = 0;
        for (int i = 0; i < NCPU*NLINES; i++)
        begin
            tag_mem[i] = TAG_RESET_WORD[26:0];
            lstate[i] = LS_INV;
        end
        lfsr = LFSR_SEED;
        act_cpus = ACTIVE_RESET;
        rd_lat = LATENCY_RESET;
        wr_lat = LATENCY_RESET;
        hi_pool[0] = '0;
        hi_pool[1] = '1;
        for (int i = 2; i < 8; i++)
            hi_pool[i] = 19'($urandom);
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: crossings, sizes, every function, wrap, victim pressure
        add_access(FN_LOAD,  2'd0, 32'h0000_0000, 2'd0);
        add_access(FN_LOAD,  2'd1, 32'h0000_001F, 2'd1);
        add_access(FN_LOAD,  2'd2, 32'h0000_003D, 2'd2);
        add_access(FN_LOAD,  2'd3, 32'h0000_005E, 2'd2);
        add_access(FN_STORE, 2'd0, 32'h0000_007D, 2'd3);
        add_access(FN_STORE, 2'd1, 32'h0000_001F, 2'd1);
        add_access(FN_LOAD,  2'd0, 32'h0000_0020, 2'd3);
        add_access(FN_LOAD,  2'd3, 32'hFFFF_FFFD, 2'd3);
        add_access(FN_STORE, 2'd2, 32'hFFFF_FFFF, 2'd2);
        add_access(FN_INVAL, 2'd2, 32'hFFFF_FFFF, 2'd3);
        add_access(FN_INVAL, 2'd1, 32'h1234_5678, 2'd0);
        add_access(FN_NONE,  2'd3, 32'hFFFF_FFFF, 2'd3);
        add_access(FN_LOAD,  2'd0, 32'h8BAD_F00D, 2'd0);
        for (int i = 0; i < 6; i++)
            add_access(FN_LOAD, 2'd1, 32'h0000_0100 + 32'(i) * 32'h2000, 2'd0);
        add_access(FN_STORE, 2'd1, 32'h0000_2100, 2'd2);
        add_access(FN_LOAD,  2'd2, 32'h0000_2100, 2'd2);
        add_access(FN_STORE, 2'd3, 32'h0000_2100, 2'd0);
        add_access(FN_LOAD,  2'd1, 32'h0000_2104, 2'd1);
        drain();

        random_phase(390);
        drain();
        write_reg(CFG_ACTIVE_CPUS, 16'd1);
        write_reg(CFG_READ_MISS, 16'd65535);
        write_reg(CFG_WRITE_LAT, 16'd0);
        send_idle = 75;
        random_phase(380);
        drain();
        write_reg(CFG_ACTIVE_CPUS, 16'd0);
        write_reg(CFG_READ_MISS, 16'd0);
        write_reg(CFG_WRITE_LAT, 16'd65535);
        send_idle = 0;
        rsp_stall = 75;
        random_phase(380);
        drain();
        write_reg(CFG_ACTIVE_CPUS, 16'd7);
        write_reg(CFG_READ_MISS, 16'd65535);
        write_reg(CFG_WRITE_LAT, 16'd65535);
        send_idle = 13;
        rsp_stall = 13;
        random_phase(200);
        drain();
        write_reg(CFG_ACTIVE_CPUS, 16'd3);
        write_reg(CFG_READ_MISS, 16'($urandom));
        write_reg(CFG_WRITE_LAT, 16'($urandom));
        random_phase(180);
        drain();

        $display("covered %0d loads, %0d stores, %0d invalidates; %0d results checked",
                 n_loads, n_stores, n_inval, checked);
        $display("four idle patterns, active cache counts 0, 1, 3, 4 and 7, %0d errors",
                 errors);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
